// File: hw/rtl/tmprof_pkg.sv
package tmprof_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned EnW      = 48;
  localparam int unsigned TickW    = 16;
  localparam int unsigned Frac     = 16;
  localparam int unsigned TickFrac = 16;
  localparam int unsigned OpAW     = 64;
  localparam int unsigned OpBW     = 33;
  localparam int unsigned ResW     = 96;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
    logic half;   // 16-bit multiplier operand
  } unit_req_t;

endpackage

// File: hw/rtl/tmprof_unit.sv
module tmprof_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tmprof_pkg::unit_req_t           req_i,
  input  logic [tmprof_pkg::OpAW-1:0]     a_i,
  input  logic [tmprof_pkg::OpBW-1:0]     b_i,
  output logic [tmprof_pkg::ResW-1:0]     res_o,
  output logic                            done_o
);
  import tmprof_pkg::*;

  logic            busy_q, done_q;
  logic [5:0]      cnt_q, count;
  op_e             op_q;
  logic [ResW-1:0] acc_q, acc_d, opa_q, opa_d;
  logic [OpBW-1:0] opb_q, opb_d;
  logic [33:0]     div_r;
  logic [35:0]     sq_r, sq_t;

  always_comb begin
    case (req_i.op)
      OP_MUL:  count = req_i.half ? 6'd15 : 6'd31;
      OP_DIV:  count = 6'd63;
      OP_SQRT: count = 6'd31;
      default: count = 6'd31;
    endcase
  end

  // one multiplier bit, quotient bit or root digit per cycle
  always_comb begin
    acc_d = acc_q;
    opa_d = opa_q;
    opb_d = opb_q;
    div_r = {acc_q[32:0], opa_q[63]};
    sq_r  = {acc_q[33:0], opa_q[63:62]};
    sq_t  = {2'b00, opb_q[31:0], 2'b01};
    case (op_q)
      OP_MUL: begin
        if (opb_q[0]) acc_d = acc_q + opa_q;
        opa_d = {opa_q[ResW-2:0], 1'b0};
        opb_d = {1'b0, opb_q[OpBW-1:1]};
      end
      OP_DIV: begin
        if (div_r >= {1'b0, opb_q}) begin
          acc_d = {62'b0, div_r - {1'b0, opb_q}};
          opa_d = {32'b0, opa_q[62:0], 1'b1};
        end else begin
          acc_d = {62'b0, div_r};
          opa_d = {32'b0, opa_q[62:0], 1'b0};
        end
      end
      OP_SQRT: begin
        opa_d = {opa_q[ResW-3:0], 2'b00};
        if (sq_r >= sq_t) begin
          acc_d = {60'b0, sq_r - sq_t};
          opb_d = {1'b0, opb_q[30:0], 1'b1};
        end else begin
          acc_d = {60'b0, sq_r};
          opb_d = {1'b0, opb_q[30:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= count;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      opa_q <= {32'b0, a_i};
      opb_q <= (req_i.op == OP_SQRT) ? '0 : b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      opa_q <= opa_d;
      opb_q <= opb_d;
    end
  end

  always_comb begin
    case (op_q)
      OP_MUL:  res_o = acc_q;
      OP_DIV:  res_o = {32'b0, opa_q[63:0]};
      OP_SQRT: res_o = {64'b0, opb_q[31:0]};
      default: res_o = acc_q;
    endcase
  end

  assign done_o = done_q;

endmodule

// File: hw/rtl/trapezoid_motion_profiler.sv
// Start transfer: seven 32-bit multiplies, three 64-bit divides and one 32-digit square
// root run in turn on the shared bit-serial unit; a zero rate starts at the K_VV multiply,
// and the root is skipped when the K_DH product overflows. Moving tick: cruise runs K_DT and
// K_FDT; decel adds K_DEC, accel K_ACC and K_AET; early stop runs K_DEC only, idle nothing.
// One item at a time; the next is taken the cycle after the result is registered.
// Reset: asynchronous, clears motion state and odometer, loads register defaults.
module trapezoid_motion_profiler (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // move_distance
  input  logic [0:0]   s_axis_tuser,   // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, remaining_distance, speed_now, step_energy, energy_used,
  // energy_estimate, odometer_total, zero pad
  output logic [263:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import tmprof_pkg::*;

  localparam logic [2:0] CfgAccel = 3'd0;
  localparam logic [2:0] CfgDecel = 3'd1;
  localparam logic [2:0] CfgVmax  = 3'd2;
  localparam logic [2:0] CfgMass  = 3'd3;
  localparam logic [2:0] CfgDrag  = 3'd4;
  localparam logic [2:0] CfgTick  = 3'd5;

  localparam logic [1:0] StatIdle    = 2'd0;
  localparam logic [1:0] StatMoving  = 2'd1;
  localparam logic [1:0] StatArrived = 2'd2;
  localparam logic [1:0] StatStopped = 2'd3;

  localparam int unsigned EnShift = 2 * Frac + 1;

  typedef enum logic [1:0] {S_IDLE, S_GO, S_WAIT, S_OUT} state_e;
  typedef enum logic [3:0] {
    K_AC, K_DIVH, K_DH, K_SQRT, K_VV, K_ZA, K_ZC, K_MV, K_AER, K_KE, K_FD,
    K_ACC, K_AET, K_DEC, K_DT, K_FDT
  } step_e;

  function automatic logic [EnW-1:0] sat_add48(input logic [EnW-1:0] a, input logic [EnW-1:0] b);
    logic [EnW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[EnW] ? '1 : s[EnW-1:0];
  endfunction

  function automatic logic [EnW-1:0] sat_shr(input logic [ResW-1:0] p);
    return (|p[ResW-1:EnShift+EnW]) ? '1 : p[EnShift+EnW-1:EnShift];
  endfunction

  function automatic logic [DataW-1:0] sat32(input logic [63:0] x);
    return (|x[63:32]) ? '1 : x[31:0];
  endfunction

  logic [DataW-1:0] accel_q, decel_q, vmax_q, mass_q, drag_q;
  logic [TickW-1:0] tick_q;

  state_e           st_q;
  step_e            step_q;
  logic             moving_q;
  logic [DataW-1:0] path_q, trav_q, speed_q, v_q, aze_q, dzl_q;
  logic [EnW-1:0]   aer_q, esum_q, odo_q;
  logic [63:0]      tmp_q;
  logic [1:0]       o_status_q;
  logic [DataW-1:0] o_rem_q, o_spd_q;
  logic [EnW-1:0]   o_step_q, o_est_q;
  logic             m_valid_q;
  logic [263:0]     m_data_q;

  unit_req_t        u_req;
  logic [OpAW-1:0]  u_a;
  logic [OpBW-1:0]  u_b;
  logic [ResW-1:0]  u_res;
  logic             u_done;

  logic [DataW-1:0] dv, delta, gap;
  logic [DataW:0]   spd_inc, pos;
  logic [EnW-1:0]   step_se;

  tmprof_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (u_req),
    .a_i    (u_a),
    .b_i    (u_b),
    .res_o  (u_res),
    .done_o (u_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= 32'd65536;
      decel_q <= 32'd65536;
      vmax_q  <= 32'd65536;
      mass_q  <= 32'd65536;
      drag_q  <= '0;
      tick_q  <= 16'd6554;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAccel: accel_q <= cfg_data_i;
        CfgDecel: decel_q <= cfg_data_i;
        CfgVmax:  vmax_q  <= cfg_data_i;
        CfgMass:  mass_q  <= cfg_data_i;
        CfgDrag:  drag_q  <= cfg_data_i;
        CfgTick:  tick_q  <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // operand routing for the shared unit
  always_comb begin
    u_req.start = (st_q == S_GO);
    u_req.op    = OP_MUL;
    u_req.half  = 1'b0;
    u_a         = '0;
    u_b         = '0;
    case (step_q)
      K_AC:   begin u_a = {32'b0, accel_q}; u_b = {1'b0, decel_q}; end
      K_DIVH: begin
        u_req.op = OP_DIV;
        u_a = tmp_q;
        u_b = {1'b0, accel_q} + {1'b0, decel_q};
      end
      K_DH:   begin u_a = {32'b0, path_q}; u_b = {1'b0, tmp_q[31:0]}; end
      K_SQRT: begin u_req.op = OP_SQRT; u_a = {tmp_q[62:0], 1'b0}; end
      K_VV:   begin u_a = {32'b0, v_q}; u_b = {1'b0, v_q}; end
      K_ZA:   begin u_req.op = OP_DIV; u_a = tmp_q; u_b = {accel_q, 1'b0}; end
      K_ZC:   begin u_req.op = OP_DIV; u_a = tmp_q; u_b = {decel_q, 1'b0}; end
      K_MV:   begin u_a = {32'b0, mass_q}; u_b = {1'b0, v_q}; end
      K_AER:  begin u_a = tmp_q; u_b = {1'b0, accel_q}; end
      K_KE:   begin u_a = tmp_q; u_b = {1'b0, v_q}; end
      K_FD:   begin u_a = {32'b0, drag_q}; u_b = {1'b0, path_q}; end
      K_ACC:  begin u_req.half = 1'b1; u_a = {32'b0, accel_q}; u_b = {17'b0, tick_q}; end
      K_AET:  begin u_req.half = 1'b1; u_a = {16'b0, aer_q}; u_b = {17'b0, tick_q}; end
      K_DEC:  begin u_req.half = 1'b1; u_a = {32'b0, decel_q}; u_b = {17'b0, tick_q}; end
      K_DT:   begin u_req.half = 1'b1; u_a = {32'b0, speed_q}; u_b = {17'b0, tick_q}; end
      K_FDT:  begin u_a = {32'b0, drag_q}; u_b = {1'b0, tmp_q[31:0]}; end
      default: ;
    endcase
  end

  always_comb begin
    dv      = u_res[TickFrac+31:TickFrac];
    delta   = tmp_q[31:0];
    gap     = (path_q > trav_q) ? (path_q - trav_q) : '0;
    spd_inc = {1'b0, speed_q} + {1'b0, u_res[TickFrac+31:TickFrac]};
    pos     = {1'b0, trav_q} + {1'b0, delta};
    step_se = sat_add48(o_step_q, u_res[Frac+47:Frac]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      step_q     <= K_AC;
      moving_q   <= 1'b0;
      path_q     <= '0;
      trav_q     <= '0;
      speed_q    <= '0;
      v_q        <= '0;
      aze_q      <= '0;
      dzl_q      <= '0;
      aer_q      <= '0;
      esum_q     <= '0;
      odo_q      <= '0;
      tmp_q      <= '0;
      o_status_q <= StatIdle;
      o_rem_q    <= '0;
      o_spd_q    <= '0;
      o_step_q   <= '0;
      o_est_q    <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
    end else begin
      if (st_q == S_OUT && (!m_valid_q || m_axis_tready)) m_valid_q <= 1'b1;
      else if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            o_est_q  <= '0;
            o_step_q <= '0;
            o_spd_q  <= '0;
            o_rem_q  <= '0;
            if (!s_axis_tuser[0]) begin
              path_q  <= s_axis_tdata;
              trav_q  <= '0;
              speed_q <= '0;
              esum_q  <= '0;
              if (s_axis_tdata == '0) begin
                moving_q   <= 1'b0;
                o_status_q <= StatArrived;
              end else begin
                moving_q   <= 1'b1;
                o_status_q <= StatMoving;
                o_rem_q    <= s_axis_tdata;
              end
              // a zero rate gives a zero peak speed
              if (accel_q == '0 || decel_q == '0) begin
                v_q    <= '0;
                step_q <= K_VV;
              end else begin
                step_q <= K_AC;
              end
              st_q <= S_GO;
            end else if (!moving_q) begin
              o_status_q <= StatIdle;
              st_q       <= S_OUT;
            end else begin
              if (trav_q < aze_q) begin
                step_q <= K_ACC;
              end else if (({1'b0, trav_q} + {1'b0, dzl_q}) > {1'b0, path_q}) begin
                step_q <= K_DEC;
              end else begin
                step_q <= K_DT;
              end
              st_q <= S_GO;
            end
          end
        end
        S_GO: st_q <= S_WAIT;
        S_WAIT: begin
          if (u_done) begin
            st_q <= S_GO;
            case (step_q)
              K_AC:   begin tmp_q <= u_res[63:0]; step_q <= K_DIVH; end
              K_DIVH: begin tmp_q <= {32'b0, u_res[31:0]}; step_q <= K_DH; end
              K_DH: begin
                tmp_q <= u_res[63:0];
                if (u_res[63]) begin
                  v_q    <= vmax_q;
                  step_q <= K_VV;
                end else begin
                  step_q <= K_SQRT;
                end
              end
              K_SQRT: begin
                v_q    <= (u_res[31:0] > vmax_q) ? vmax_q : u_res[31:0];
                step_q <= K_VV;
              end
              K_VV:   begin tmp_q <= u_res[63:0]; step_q <= K_ZA; end
              K_ZA: begin
                aze_q  <= (accel_q == '0) ? '0 : sat32(u_res[63:0]);
                step_q <= K_ZC;
              end
              K_ZC: begin
                dzl_q  <= (decel_q == '0) ? '0 : sat32(u_res[63:0]);
                step_q <= K_MV;
              end
              K_MV:   begin tmp_q <= u_res[63:0]; step_q <= K_AER; end
              K_AER:  begin aer_q <= sat_shr(u_res); step_q <= K_KE; end
              K_KE:   begin tmp_q <= {16'b0, sat_shr(u_res)}; step_q <= K_FD; end
              K_FD: begin
                o_est_q <= sat_add48(tmp_q[EnW-1:0], u_res[Frac+47:Frac]);
                st_q    <= S_OUT;
              end
              K_ACC: begin
                speed_q <= spd_inc[DataW] ? '1 : spd_inc[DataW-1:0];
                step_q  <= K_AET;
              end
              K_AET: begin
                o_step_q <= u_res[TickFrac+47:TickFrac];
                step_q   <= K_DT;
              end
              K_DEC: begin
                if (dv > speed_q) begin
                  // stop short: snap to target
                  odo_q      <= odo_q + {16'b0, gap};
                  trav_q     <= path_q;
                  speed_q    <= '0;
                  moving_q   <= 1'b0;
                  o_status_q <= StatStopped;
                  st_q       <= S_OUT;
                end else begin
                  speed_q <= speed_q - dv;
                  step_q  <= K_DT;
                end
              end
              K_DT: begin
                tmp_q  <= {32'b0, u_res[TickFrac+31:TickFrac]};
                step_q <= K_FDT;
              end
              K_FDT: begin
                o_step_q <= step_se;
                esum_q   <= sat_add48(esum_q, step_se);
                odo_q    <= odo_q + {16'b0, delta};
                o_spd_q  <= speed_q;
                if (pos >= {1'b0, path_q}) begin
                  trav_q     <= path_q;
                  speed_q    <= '0;
                  moving_q   <= 1'b0;
                  o_status_q <= StatArrived;
                end else begin
                  trav_q     <= pos[DataW-1:0];
                  o_rem_q    <= path_q - pos[DataW-1:0];
                  o_status_q <= StatMoving;
                end
                st_q <= S_OUT;
              end
              default: st_q <= S_OUT;
            endcase
          end
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= {6'b0, odo_q, o_est_q, esum_q, o_step_q, o_spd_q, o_rem_q,
                          o_status_q};
            st_q      <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
